// File: hw/rtl/twq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twq_pkg
// Shared constants, codes and types of the two-queue weighted drain block.
// ----------------------------------------------------------------------------
package twq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int NORMAL_EVERY = 3;
  localparam int ID_W         = 32;
  localparam int IDX_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W       = $clog2(NORMAL_EVERY);

  localparam logic [1:0] ACT_ENQ_NORMAL = 2'd0;
  localparam logic [1:0] ACT_ENQ_PRIO   = 2'd1;
  localparam logic [1:0] ACT_DRAIN      = 2'd2;

  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_SERVED   = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [ID_W-1:0] served_id;
    logic                   from_priority;
    logic                   last;
  } res_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_tail(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] count);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, count};
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: hw/rtl/twq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module twq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/twq_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twq_out_buf
// Two-entry result buffer between the result stage and the output channel.
// ----------------------------------------------------------------------------
module twq_out_buf
  import twq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  res_t       push_res,
  output logic [1:0] cnt,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  res_t ent [2];
  logic wr_ptr;
  logic rd_ptr;
  logic pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_res   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hw/rtl/two_queue_weighted_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_weighted_drain
// Normal and priority id FIFOs held in two RAMs, with a weighted drain.
//
// Input channel (in_valid/in_ready) carries action and item_id. An enqueue
// beat gives one result beat (accepted or full). A drain beat walks both
// FIFOs: every NORMAL_EVERY-th slot goes to the normal FIFO while both hold
// ids, all other slots to the priority FIFO, and once one is empty the other
// is drained; one served-id beat per cycle while the result buffer has room,
// the final one with last set. A drain of two empty FIFOs gives one empty
// beat. Action code 3 is taken and gives no beat. Enqueue: one beat per
// cycle while the result buffer has room. A drain holds off the next input
// beat until its last id is read. Results pass the registered RAM read and
// the result buffer; one read port per RAM sets the rate, one id per cycle.
// Reset empties both FIFOs at once (counts and heads to zero); RAM contents
// are not cleared. When the receiver stalls, a two-entry result buffer fills,
// then RAM reads and input beats hold until room frees up.
// ----------------------------------------------------------------------------
module two_queue_weighted_drain
  import twq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic signed [ID_W-1:0] item_id,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic signed [ID_W-1:0] served_id,
  output logic                   from_priority,
  output logic                   last
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] n_head;
  logic [IDX_W-1:0] p_head;
  logic [CNT_W-1:0] n_count;
  logic [CNT_W-1:0] p_count;
  logic [SLOT_W-1:0] slot_mod;

  logic       s1_valid;
  logic       s1_served;
  logic       s1_prio;
  logic [1:0] s1_status;
  logic       s1_last;

  logic [1:0]      fifo_cnt;
  logic            pop;
  logic            room;
  logic            in_fire;
  logic            drain_issue;
  logic            take_prio;
  logic            n_full;
  logic            p_full;
  logic            drain_last;
  logic [CNT_W:0]  total;
  logic [ID_W-1:0] n_rdata;
  logic [ID_W-1:0] p_rdata;
  res_t            push_res;
  res_t            out_res;

  assign pop   = out_valid && out_ready;
  assign room  = ({1'b0, fifo_cnt} + {2'b00, s1_valid}) < (3'd2 + {2'b00, pop});
  assign in_ready    = (state == ST_IDLE) && room;
  assign in_fire     = in_valid && in_ready;
  assign drain_issue = (state == ST_DRAIN) && room;

  assign n_full     = (n_count == CNT_W'(QUEUE_DEPTH));
  assign p_full     = (p_count == CNT_W'(QUEUE_DEPTH));
  assign total      = {1'b0, n_count} + {1'b0, p_count};
  assign drain_last = (total == (CNT_W + 1)'(1));
  assign take_prio  = (p_count != '0) && !((slot_mod == '0) && (n_count != '0));

  twq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_W)) u_normal_ram (
    .clk   (clk),
    .we    (in_fire && (action == ACT_ENQ_NORMAL) && !n_full),
    .waddr (idx_tail(n_head, n_count)),
    .wdata (item_id),
    .re    (drain_issue && !take_prio),
    .raddr (n_head),
    .rdata (n_rdata)
  );

  twq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_W)) u_priority_ram (
    .clk   (clk),
    .we    (in_fire && (action == ACT_ENQ_PRIO) && !p_full),
    .waddr (idx_tail(p_head, p_count)),
    .wdata (item_id),
    .re    (drain_issue && take_prio),
    .raddr (p_head),
    .rdata (p_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      n_head   <= '0;
      p_head   <= '0;
      n_count  <= '0;
      p_count  <= '0;
      slot_mod <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (action)
              ACT_ENQ_NORMAL: begin
                s1_valid  <= 1'b1;
                s1_served <= 1'b0;
                s1_prio   <= 1'b0;
                s1_last   <= 1'b1;
                s1_status <= n_full ? STAT_FULL : STAT_ACCEPTED;
                if (!n_full) begin
                  n_count <= n_count + CNT_W'(1);
                end
              end
              ACT_ENQ_PRIO: begin
                s1_valid  <= 1'b1;
                s1_served <= 1'b0;
                s1_prio   <= 1'b0;
                s1_last   <= 1'b1;
                s1_status <= p_full ? STAT_FULL : STAT_ACCEPTED;
                if (!p_full) begin
                  p_count <= p_count + CNT_W'(1);
                end
              end
              ACT_DRAIN: begin
                slot_mod <= SLOT_W'(1);
                if (total == '0) begin
                  s1_valid  <= 1'b1;
                  s1_served <= 1'b0;
                  s1_prio   <= 1'b0;
                  s1_last   <= 1'b1;
                  s1_status <= STAT_EMPTY;
                end else begin
                  state <= ST_DRAIN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DRAIN: begin
          if (drain_issue) begin
            s1_valid  <= 1'b1;
            s1_served <= 1'b1;
            s1_prio   <= take_prio;
            s1_last   <= drain_last;
            s1_status <= STAT_SERVED;
            slot_mod  <= (slot_mod == SLOT_W'(NORMAL_EVERY - 1)) ? '0
                                                                 : slot_mod + SLOT_W'(1);
            if (take_prio) begin
              p_head  <= idx_inc(p_head);
              p_count <= p_count - CNT_W'(1);
            end else begin
              n_head  <= idx_inc(n_head);
              n_count <= n_count - CNT_W'(1);
            end
            if (drain_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    push_res.status        = s1_status;
    push_res.served_id     = s1_served ? (s1_prio ? p_rdata : n_rdata) : '0;
    push_res.from_priority = s1_served && s1_prio;
    push_res.last          = s1_last;
  end

  twq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_res  (push_res),
    .cnt       (fifo_cnt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status        = out_res.status;
  assign served_id     = out_res.served_id;
  assign from_priority = out_res.from_priority;
  assign last          = out_res.last;

endmodule

// File: hw/rtl/twq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twq_checker
// Port-level checks of the result channel of the weighted drain block.
// ----------------------------------------------------------------------------
module twq_checker
  import twq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             status,
  input logic signed [ID_W-1:0] served_id,
  input logic                   from_priority,
  input logic                   last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_EMPTY) |-> last && (served_id == '0) && !from_priority)
    else $error("empty drain beat malformed");

  a_non_served_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_SERVED) |-> (served_id == '0) && !from_priority)
    else $error("id or priority flag set on non-served beat");

  a_enqueue_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == STAT_ACCEPTED) || (status == STAT_FULL)) |-> last)
    else $error("enqueue answer without last");

endmodule

bind two_queue_weighted_drain twq_checker u_twq_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .served_id     (served_id),
  .from_priority (from_priority),
  .last          (last)
);

// File: bench/two_queue_weighted_drain_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_weighted_drain_tb
// Self-checking bench for the two-queue weighted drain block. A directed table
// covers the corner cases: empty drain, full FIFO, extreme ids and the unused
// action code. A receiver hold-off then fills the block, and the sender pauses
// until the bench has caught up. Random enqueue bursts followed by drains come
// last, with random gaps and stalls on both channels.
// Each result beat is checked against a mirror of both FIFOs or a table row.
// ----------------------------------------------------------------------------
module two_queue_weighted_drain_tb;
  import twq_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]      act;
    logic [ID_W-1:0] id;
    logic [4:0]      reps;
    logic            typed;
    logic [1:0]      stat;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             action;
  logic signed [ID_W-1:0] item_id;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             status;
  logic signed [ID_W-1:0] served_id;
  logic                   from_priority;
  logic                   last;

  logic signed [ID_W-1:0] normal_ids[$];
  logic signed [ID_W-1:0] prio_ids[$];
  res_t                   pending[$];

  int error_count = 0;
  int beats_in    = 0;
  int next_gap    = 1;
  int hold_len    = 0;
  bit steady      = 1'b0;

  stim_row_t plan [10] = '{
    '{ACT_DRAIN,      32'h0000_0000, 5'd1,  1'b1, STAT_EMPTY},
    '{ACT_UNUSED,     32'h1234_5678, 5'd1,  1'b0, STAT_ACCEPTED},
    '{ACT_ENQ_NORMAL, 32'h7fff_ffff, 5'd1,  1'b1, STAT_ACCEPTED},
    '{ACT_ENQ_NORMAL, 32'h8000_0000, 5'd1,  1'b1, STAT_ACCEPTED},
    '{ACT_ENQ_PRIO,   32'h0000_0000, 5'd1,  1'b1, STAT_ACCEPTED},
    '{ACT_ENQ_PRIO,   32'hffff_ffff, 5'd1,  1'b1, STAT_ACCEPTED},
    '{ACT_DRAIN,      32'hffff_ffff, 5'd1,  1'b0, STAT_ACCEPTED},
    '{ACT_ENQ_PRIO,   32'h0000_1000, 5'd16, 1'b0, STAT_ACCEPTED},
    '{ACT_ENQ_PRIO,   32'h0000_2000, 5'd1,  1'b1, STAT_FULL},
    '{ACT_DRAIN,      32'h5555_aaaa, 5'd1,  1'b0, STAT_ACCEPTED}
  };

  two_queue_weighted_drain dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .item_id       (item_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .served_id     (served_id),
    .from_priority (from_priority),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("two_queue_weighted_drain_tb: errors");
    $finish;
  end

  task automatic note_error(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // mirror of both fifos; keep=0 only advances the mirror
  function automatic void predict_results(input logic [1:0] act,
                                          input logic signed [ID_W-1:0] id,
                                          input bit keep);
    int total;
    bit take_prio;
    res_t r;
    r = '0;
    r.last = 1'b1;
    case (act)
      ACT_ENQ_NORMAL: begin
        if (normal_ids.size() >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          normal_ids.push_back(id);
          r.status = STAT_ACCEPTED;
        end
        if (keep) pending.push_back(r);
      end
      ACT_ENQ_PRIO: begin
        if (prio_ids.size() >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          prio_ids.push_back(id);
          r.status = STAT_ACCEPTED;
        end
        if (keep) pending.push_back(r);
      end
      ACT_DRAIN: begin
        total = normal_ids.size() + prio_ids.size();
        if (total == 0) begin
          r.status = STAT_EMPTY;
          if (keep) pending.push_back(r);
        end
        for (int slot = 1; slot <= total; slot++) begin
          take_prio = (prio_ids.size() != 0) &&
                      !((slot % NORMAL_EVERY) == 0 && normal_ids.size() != 0);
          r.status        = STAT_SERVED;
          r.served_id     = take_prio ? prio_ids.pop_front() : normal_ids.pop_front();
          r.from_priority = take_prio;
          r.last          = (slot == total);
          if (keep) pending.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] act, input logic signed [ID_W-1:0] id,
                           input bit typed, input logic [1:0] typed_status);
    res_t r;
    if (next_gap != 0) repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    action   <= act;
    item_id  <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_results(act, id, !typed);
    if (typed) begin
      r = '0;
      r.status = typed_status;
      r.last   = 1'b1;
      pending.push_back(r);
    end
    if (act != ACT_UNUSED) beats_in++;
    next_gap = steady ? 0 : $urandom_range(0, 10);
    if (next_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic wait_all_served();
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
    while (pending.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall after each beat, plus requested long hold-offs
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        stall = hold_len;
        hold_len = 0;
      end else if (out_valid && out_ready) begin
        stall = steady ? 0 : $urandom_range(0, 10);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, served_id, from_priority, last};
      #1;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected beat status=%0d id=%0d", got.status,
                             got.served_id));
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status)
          note_error($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.served_id !== want.served_id)
          note_error($sformatf("served_id %0d, expected %0d", got.served_id,
                               want.served_id));
        if (got.from_priority !== want.from_priority)
          note_error($sformatf("from_priority %0b, expected %0b", got.from_priority,
                               want.from_priority));
        if (got.last !== want.last)
          note_error($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    end
  end

  initial begin
    int n_enq;
    int prio_pct;
    logic [1:0] act;
    logic signed [ID_W-1:0] v;
    in_valid <= 1'b0;
    action   <= ACT_ENQ_NORMAL;
    item_id  <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        send_beat(plan[i].act, plan[i].id + ID_W'(k), plan[i].typed, plan[i].stat);
      end
    end
    wait_all_served();

    // receiver holds off while beats keep coming, so the block backs up
    steady = 1'b1;
    hold_len = 60;
    repeat (24) send_beat(ACT_ENQ_NORMAL, $urandom, 1'b0, STAT_ACCEPTED);
    send_beat(ACT_DRAIN, $urandom, 1'b0, STAT_ACCEPTED);
    wait_all_served();
    steady = 1'b0;

    while (beats_in < 300) begin
      steady   = ($urandom_range(0, 4) == 0);
      prio_pct = $urandom_range(0, 100);
      n_enq    = $urandom_range(0, 20);
      repeat (n_enq) begin
        act = ($urandom_range(0, 99) < prio_pct) ? ACT_ENQ_PRIO : ACT_ENQ_NORMAL;
        case ($urandom_range(0, 15))
          0: v = 32'sh7fff_ffff;
          1: v = 32'sh8000_0000;
          2: v = '0;
          3: v = '1;
          default: v = $urandom;
        endcase
        send_beat(act, v, 1'b0, STAT_ACCEPTED);
      end
      if ($urandom_range(0, 19) == 0) send_beat(ACT_UNUSED, $urandom, 1'b0, STAT_ACCEPTED);
      if ($urandom_range(0, 9) != 0) send_beat(ACT_DRAIN, $urandom, 1'b0, STAT_ACCEPTED);
      if ($urandom_range(0, 7) == 0) wait_all_served();
    end

    wait_all_served();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("two_queue_weighted_drain_tb: clean");
    end else begin
      $display("two_queue_weighted_drain_tb: errors");
    end
    $finish;
  end

endmodule
